// ===== src/tsfp_pkg.sv =====
// Package for the sync/type/length/value frame parser.
// Holds payload structs, parser phases, queue event types and config constants.
// No dependencies.
package tsfp_pkg;

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [7:0] frame_type;
        logic       first_of_frame;
        logic       last_of_frame;
        logic       aborted;
    } t_out_item;

    typedef enum logic [2:0] {
        PH_SYNC0,
        PH_SYNC1,
        PH_TYPE,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_PAYLOAD
    } t_phase;

    // back end position within a three-byte header
    typedef enum logic [1:0] {
        HS_IDLE,
        HS_LEN_HI,
        HS_LEN_LO
    } t_hdr_step;

    // one queue entry per accepted transaction that yields output
    typedef enum logic [1:0] {
        EV_HDR,
        EV_DATA,
        EV_ABORT
    } t_evt_kind;

    typedef struct packed {
        t_evt_kind  kind;
        logic [7:0] b0;     // data byte, or length high for a header
        logic [7:0] b1;     // length low for a header
        logic [7:0] ftype;
        logic       last;
    } t_evt;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC_BYTES    = 3'd0,
        CFG_TYPE_CODES    = 3'd1,
        CFG_FIXED_LENGTHS = 3'd2,
        CFG_MAX_PAYLOAD   = 3'd3,
        CFG_MIC_MAX       = 3'd4,
        CFG_AUDIO_ENABLE  = 3'd5
    } t_cfg_idx;

    localparam logic [15:0] RST_SYNC_BYTES    = 16'hAA55;
    localparam logic [31:0] RST_TYPE_CODES    = 32'h0403_0201;
    localparam logic [47:0] RST_FIXED_LENGTHS = 48'h0;
    localparam logic [15:0] RST_MAX_PAYLOAD   = 16'd512;
    localparam logic [15:0] RST_MIC_MAX       = 16'd0;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

endpackage

// ===== src/tsfp_queue.sv =====
// Short event queue between the parser front end and the output back end.
// Depends on tsfp_pkg (t_evt, queue depth constants).
module tsfp_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tsfp_pkg::t_evt i_evt,
    input  logic          i_pop,
    output tsfp_pkg::t_evt o_head,
    output logic          o_empty,
    output logic          o_full
);
    import tsfp_pkg::*;

    t_evt                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_CW-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== src/tsfp_front.sv =====
// Parser front end: config registers, sync hunt and header checks.
// Emits one queue event per transaction that produces output. Depends on tsfp_pkg.
module tsfp_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [tsfp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tsfp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    input  tsfp_pkg::t_in_item                i_in_item,
    input  logic                              i_queue_full,
    output logic                              o_in_stall,
    output logic                              o_push,
    output tsfp_pkg::t_evt                    o_evt
);
    import tsfp_pkg::*;

    logic [15:0] r_sync;
    logic [31:0] r_types;
    logic [47:0] r_fixed;
    logic [15:0] r_max_pay;
    logic [15:0] r_mic_max;
    logic        r_audio_en;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_type,  n_type;
    logic [15:0] r_len,   n_len;
    logic [15:0] r_cnt,   n_cnt;

    logic        accept;
    logic [7:0]  b;
    logic [7:0]  s0, s1;
    logic [15:0] len_full;
    logic [15:0] cnt_inc;
    logic        pay_last;
    logic [3:0]  type_hit;   // byte in hand matches code k
    logic [3:0]  held_hit;   // held type matches code k
    logic        len_ok;

    assign o_in_stall = i_queue_full;
    assign accept     = i_in_valid && !i_queue_full;
    assign b          = i_in_item.data_byte;
    assign s0         = r_sync[15:8];
    assign s1         = r_sync[7:0];
    assign len_full   = {r_len[15:8], b};
    assign cnt_inc    = r_cnt + 16'd1;
    assign pay_last   = (cnt_inc >= r_len);

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            type_hit[k] = (r_types[8*k +: 8] == b);
            held_hit[k] = (r_types[8*k +: 8] == r_type);
        end
    end

    // first matching code decides the rule
    always_comb begin
        if (len_full > r_max_pay) begin
            len_ok = 1'b0;
        end else if (held_hit[0]) begin
            len_ok = (len_full == r_fixed[15:0]);
        end else if (held_hit[1]) begin
            len_ok = (len_full == r_fixed[31:16]);
        end else if (held_hit[2]) begin
            len_ok = (len_full == r_fixed[47:32]);
        end else if (held_hit[3]) begin
            len_ok = r_audio_en && (len_full != 16'd0) && !len_full[0]
                     && ((r_mic_max == 16'd0) || (len_full <= r_mic_max));
        end else begin
            len_ok = 1'b0;
        end
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        n_type  = r_type;
        n_len   = r_len;
        n_cnt   = r_cnt;
        if (accept) begin
            if (i_in_item.command) begin
                n_phase = PH_SYNC0;
                n_len   = '0;
                n_cnt   = '0;
            end else begin
                case (r_phase)
                    PH_SYNC0: begin
                        if (b == s0) n_phase = PH_SYNC1;
                    end
                    PH_SYNC1: begin
                        if (b == s1)      n_phase = PH_TYPE;
                        else if (b == s0) n_phase = PH_SYNC1;
                        else              n_phase = PH_SYNC0;
                    end
                    PH_TYPE: begin
                        if (type_hit == 4'b0000) begin
                            n_phase = (b == s0) ? PH_SYNC1 : PH_SYNC0;
                        end else begin
                            n_type  = b;
                            n_phase = PH_LEN_HI;
                        end
                    end
                    PH_LEN_HI: begin
                        n_len   = {b, 8'h00};
                        n_phase = PH_LEN_LO;
                    end
                    PH_LEN_LO: begin
                        n_len = len_full;
                        if (!len_ok || (len_full == 16'd0)) begin
                            n_phase = PH_SYNC0;
                            n_len   = '0;
                            n_cnt   = '0;
                        end else begin
                            n_cnt   = '0;
                            n_phase = PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD: begin
                        if (pay_last) begin
                            n_phase = PH_SYNC0;
                            n_len   = '0;
                            n_cnt   = '0;
                        end else begin
                            n_cnt = cnt_inc;
                        end
                    end
                    default: begin
                        n_phase = PH_SYNC0;
                        n_len   = '0;
                        n_cnt   = '0;
                    end
                endcase
            end
        end
    end

    // queue events
    always_comb begin
        o_push      = 1'b0;
        o_evt.kind  = EV_DATA;
        o_evt.b0    = b;
        o_evt.b1    = b;
        o_evt.ftype = r_type;
        o_evt.last  = 1'b0;
        if (accept) begin
            if (i_in_item.command) begin
                o_push      = (r_phase == PH_PAYLOAD);
                o_evt.kind  = EV_ABORT;
            end else begin
                case (r_phase)
                    PH_LEN_LO: begin
                        o_push     = len_ok;
                        o_evt.kind = EV_HDR;
                        o_evt.b0   = r_len[15:8];
                        o_evt.last = (len_full == 16'd0);
                    end
                    PH_PAYLOAD: begin
                        o_push     = 1'b1;
                        o_evt.last = pay_last;
                    end
                    default: o_push = 1'b0;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync     <= RST_SYNC_BYTES;
            r_types    <= RST_TYPE_CODES;
            r_fixed    <= RST_FIXED_LENGTHS;
            r_max_pay  <= RST_MAX_PAYLOAD;
            r_mic_max  <= RST_MIC_MAX;
            r_audio_en <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_SYNC_BYTES:    r_sync     <= i_cfg_data[15:0];
                CFG_TYPE_CODES:    r_types    <= i_cfg_data[31:0];
                CFG_FIXED_LENGTHS: r_fixed    <= i_cfg_data[47:0];
                CFG_MAX_PAYLOAD:   r_max_pay  <= i_cfg_data[15:0];
                CFG_MIC_MAX:       r_mic_max  <= i_cfg_data[15:0];
                CFG_AUDIO_ENABLE:  r_audio_en <= i_cfg_data[0];
                default:           r_audio_en <= r_audio_en;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SYNC0;
            r_type  <= '0;
            r_len   <= '0;
            r_cnt   <= '0;
        end else begin
            r_phase <= n_phase;
            r_type  <= n_type;
            r_len   <= n_len;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ===== src/tsfp_back.sv =====
// Output back end: expands queue events into result transactions.
// A header event becomes three bytes; output register decouples the receiver.
// Depends on tsfp_pkg.
module tsfp_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tsfp_pkg::t_evt      i_head,
    input  logic                i_empty,
    output logic                o_pop,
    output logic                o_out_valid,
    output tsfp_pkg::t_out_item o_out_item,
    input  logic                i_out_stall
);
    import tsfp_pkg::*;

    t_hdr_step r_step, n_step;
    t_evt      r_hdr;
    logic      r_valid, n_valid;
    t_out_item r_out,   n_out;
    logic      load;

    assign load        = !r_valid || !i_out_stall;
    assign o_out_valid = r_valid;
    assign o_out_item  = r_out;

    // next state
    always_comb begin
        n_step = r_step;
        if (load) begin
            case (r_step)
                HS_LEN_HI: n_step = HS_LEN_LO;
                HS_LEN_LO: n_step = HS_IDLE;
                default: begin
                    if (!i_empty && (i_head.kind == EV_HDR)) n_step = HS_LEN_HI;
                end
            endcase
        end
    end

    // outputs
    always_comb begin
        n_valid = r_valid;
        n_out   = r_out;
        o_pop   = 1'b0;
        if (load) begin
            n_valid = 1'b0;
            case (r_step)
                HS_LEN_HI: begin
                    n_valid = 1'b1;
                    n_out   = '{out_byte: r_hdr.b0, frame_type: r_hdr.ftype,
                                first_of_frame: 1'b0, last_of_frame: 1'b0, aborted: 1'b0};
                end
                HS_LEN_LO: begin
                    n_valid = 1'b1;
                    n_out   = '{out_byte: r_hdr.b1, frame_type: r_hdr.ftype,
                                first_of_frame: 1'b0, last_of_frame: r_hdr.last,
                                aborted: 1'b0};
                end
                default: begin
                    if (!i_empty) begin
                        o_pop   = 1'b1;
                        n_valid = 1'b1;
                        case (i_head.kind)
                            EV_HDR: begin
                                n_out  = '{out_byte: i_head.ftype, frame_type: i_head.ftype,
                                           first_of_frame: 1'b1, last_of_frame: 1'b0,
                                           aborted: 1'b0};
                            end
                            EV_ABORT: begin
                                n_out = '{out_byte: 8'h00, frame_type: i_head.ftype,
                                          first_of_frame: 1'b0, last_of_frame: 1'b0,
                                          aborted: 1'b1};
                            end
                            default: begin
                                n_out = '{out_byte: i_head.b0, frame_type: i_head.ftype,
                                          first_of_frame: 1'b0, last_of_frame: i_head.last,
                                          aborted: 1'b0};
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && (i_head.kind == EV_HDR)) begin
            r_hdr <= i_head;
        end
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= HS_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_step  <= n_step;
            r_valid <= n_valid;
        end
    end

endmodule

// ===== src/tlv_sync_frame_parser.sv =====
// Top level of the sync/type/length/value frame parser.
// Depends on tsfp_pkg, tsfp_front, tsfp_queue, tsfp_back.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item) carries one stream
//   byte or a resync command per transaction. Output channel (o_out_valid /
//   i_out_stall / o_out_item) carries one frame byte per transaction: type,
//   length high, length low, then payload, with first/last flags; a resync
//   inside a payload yields one transaction with aborted set.
//   Config port: write i_cfg_data to register i_cfg_index while i_cfg_wr_en
//   is high; write only while the block is idle.
// Timing:
//   One input byte per cycle while o_in_stall is low. A result passes through
//   the event queue and then the output register. The back end drains one
//   result per cycle while the receiver does not stall, and turns each header
//   into three output bytes; a four-entry event queue absorbs these and
//   o_in_stall rises only when it is full.
// Reset: synchronous, active low; parser goes to the first sync hunt, the
//   queue empties and config registers take their default values.
// Receiver stall: the output register holds its transaction; the queue fills
//   and then stalls the input.
module tlv_sync_frame_parser (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [tsfp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tsfp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  tsfp_pkg::t_in_item               i_in_item,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output tsfp_pkg::t_out_item              o_out_item
);
    import tsfp_pkg::*;

    logic push;
    t_evt push_evt;
    t_evt head;
    logic pop;
    logic empty;
    logic full;

    tsfp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_item    (i_in_item),
        .i_queue_full (full),
        .o_in_stall   (o_in_stall),
        .o_push       (push),
        .o_evt        (push_evt)
    );

    tsfp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_evt   (push_evt),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty),
        .o_full  (full)
    );

    tsfp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

endmodule

// ===== verif/tb_tlv_sync_frame_parser.sv =====
`timescale 1ns / 100ps
// Testbench for tlv_sync_frame_parser: a directed table of frames, then random framed
// traffic with random stalls on both channels, checked byte by byte against a parser model.
// Depends on tsfp_pkg and the tlv_sync_frame_parser RTL.
module tb_tlv_sync_frame_parser;
    import tsfp_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int PRESSURE_HOLD  = 80;
    localparam int PHASE_ITEMS    = 45;
    localparam int NUM_PHASES     = 6;
    localparam int PREDICTED      = -1;
    localparam int LEN_CAP        = 24;

    typedef struct {
        logic [15:0] sync;
        logic [31:0] types;
        logic [47:0] fixed;
        logic [15:0] max_payload;
        logic [15:0] mic_max;
        logic        audio;
    } t_link_setup;

    typedef struct {
        t_in_item  item;
        int        n_typed;     // PREDICTED: results come from the parser model
        t_out_item r0;
        t_out_item r1;
        t_out_item r2;
    } t_script_row;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    t_cfg_idx              i_cfg_index = CFG_SYNC_BYTES;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in_item   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_item;

    // parser model state
    t_link_setup cfg;
    t_phase      phase;
    logic [7:0]  held_type;
    logic [15:0] want_len;
    logic [15:0] got_count;

    t_out_item   produced[$];
    t_out_item   frame_bytes_due[$];
    t_script_row script[$];
    t_in_item    burst[$];
    int          fail_count   = 0;
    int          quiet_cycles = 0;
    bit          calm         = 1'b0;
    bit          hold_request = 1'b0;

    tlv_sync_frame_parser i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always #2 i_clk = ~i_clk;

    function automatic t_out_item frame_byte(input logic [7:0] b, input logic [7:0] t,
                                             input logic first, input logic last,
                                             input logic abrt);
        t_out_item r;
        r.out_byte       = b;
        r.frame_type     = t;
        r.first_of_frame = first;
        r.last_of_frame  = last;
        r.aborted        = abrt;
        return r;
    endfunction

    function automatic t_in_item data_item(input logic [7:0] b);
        t_in_item it;
        it.command   = 1'b0;
        it.data_byte = b;
        return it;
    endfunction

    function automatic t_in_item resync_item();
        t_in_item it;
        it.command   = 1'b1;
        it.data_byte = 8'($urandom);
        return it;
    endfunction

    function automatic t_script_row row(input logic cmd, input logic [7:0] b,
                                        input int n = PREDICTED, input t_out_item r0 = '0,
                                        input t_out_item r1 = '0, input t_out_item r2 = '0);
        t_script_row x;
        x.item.command   = cmd;
        x.item.data_byte = b;
        x.n_typed        = n;
        x.r0             = r0;
        x.r1             = r1;
        x.r2             = r2;
        return x;
    endfunction

    // first matching code wins, 4 means no match
    function automatic int slot_of(input logic [7:0] t);
        for (int k = 0; k < 4; k++)
            if (cfg.types[8*k +: 8] == t) return k;
        return 4;
    endfunction

    function automatic bit length_fits(input int slot, input logic [15:0] len);
        if (len > cfg.max_payload) return 1'b0;
        if (slot < 3) return len == cfg.fixed[16*slot +: 16];
        if (slot == 3)
            return cfg.audio && len != 0 && !len[0] &&
                   !(cfg.mic_max != 0 && len > cfg.mic_max);
        return 1'b0;
    endfunction

    function automatic void restart_hunt();
        phase     = PH_SYNC0;
        want_len  = '0;
        got_count = '0;
    endfunction

    // advance the parser model by one transaction; results land in produced
    function automatic void parse_byte(input t_in_item it);
        logic [7:0] s0, s1, b;
        s0 = cfg.sync[15:8];
        s1 = cfg.sync[7:0];
        b  = it.data_byte;
        produced.delete();
        if (it.command) begin
            if (phase == PH_PAYLOAD)
                produced.push_back(frame_byte(8'h00, held_type, 1'b0, 1'b0, 1'b1));
            restart_hunt();
            return;
        end
        case (phase)
            PH_SYNC0: begin
                if (b == s0) phase = PH_SYNC1;
            end
            PH_SYNC1: begin
                if (b == s1) phase = PH_TYPE;
                else if (b == s0) phase = PH_SYNC1;
                else phase = PH_SYNC0;
            end
            PH_TYPE: begin
                if (slot_of(b) > 3) begin
                    if (b == s0) phase = PH_SYNC1;
                    else phase = PH_SYNC0;
                end else begin
                    held_type = b;
                    phase     = PH_LEN_HI;
                end
            end
            PH_LEN_HI: begin
                want_len = {b, 8'h00};
                phase    = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                want_len[7:0] = b;
                if (!length_fits(slot_of(held_type), want_len)) begin
                    restart_hunt();
                end else begin
                    produced.push_back(frame_byte(held_type, held_type, 1'b1, 1'b0, 1'b0));
                    produced.push_back(frame_byte(want_len[15:8], held_type, 1'b0, 1'b0, 1'b0));
                    produced.push_back(frame_byte(want_len[7:0], held_type, 1'b0,
                                                  want_len == 0, 1'b0));
                    if (want_len == 0) begin
                        restart_hunt();
                    end else begin
                        got_count = '0;
                        phase     = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                got_count = got_count + 16'd1;
                if (got_count >= want_len) begin
                    produced.push_back(frame_byte(b, held_type, 1'b0, 1'b1, 1'b0));
                    restart_hunt();
                end else begin
                    produced.push_back(frame_byte(b, held_type, 1'b0, 1'b0, 1'b0));
                end
            end
            default: restart_hunt();
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [7:0] exp_v,
                                        input logic [7:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s expected %0h actual %0h", name, exp_v, got_v);
            fail_count++;
        end
    endfunction

    // offer one transaction, return at the edge that accepts it
    task automatic send_byte(input t_in_item it, input bit use_model);
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        parse_byte(it);
        if (use_model)
            foreach (produced[k]) frame_bytes_due.push_back(produced[k]);
    endtask

    task automatic run_script();
        foreach (script[i]) begin
            send_byte(script[i].item, script[i].n_typed == PREDICTED);
            if (script[i].n_typed > 0) frame_bytes_due.push_back(script[i].r0);
            if (script[i].n_typed > 1) frame_bytes_due.push_back(script[i].r1);
            if (script[i].n_typed > 2) frame_bytes_due.push_back(script[i].r2);
        end
        script.delete();
    endtask

    // drain, then give bytes that produce nothing time to clear the pipeline
    task automatic settle();
        i_in_valid <= 1'b0;
        while (frame_bytes_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_setup(input t_link_setup s);
        t_cfg_idx idx;
        for (int r = 0; r <= int'(CFG_AUDIO_ENABLE); r++) begin
            idx = t_cfg_idx'(r);
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= idx;
            case (idx)
                CFG_SYNC_BYTES:    i_cfg_data <= 48'(s.sync);
                CFG_TYPE_CODES:    i_cfg_data <= 48'(s.types);
                CFG_FIXED_LENGTHS: i_cfg_data <= s.fixed;
                CFG_MAX_PAYLOAD:   i_cfg_data <= 48'(s.max_payload);
                CFG_MIC_MAX:       i_cfg_data <= 48'(s.mic_max);
                CFG_AUDIO_ENABLE:  i_cfg_data <= 48'(s.audio);
                default:           i_cfg_data <= '0;
            endcase
            @(posedge i_clk);
        end
        i_cfg_wr_en <= 1'b0;
        cfg = s;
    endtask

    // receiver: random stall bursts, one long hold on request
    always begin
        @(posedge i_clk);
        if (hold_request) begin
            hold_request = 1'b0;
            i_out_stall <= 1'b1;
            repeat (PRESSURE_HOLD) @(posedge i_clk);
            i_out_stall <= 1'b0;
        end else if (!calm && $urandom_range(0, 4) == 0) begin
            i_out_stall <= 1'b1;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (frame_bytes_due.size() == 0) begin
                $error("unexpected transaction: out_byte %0h frame_type %0h",
                       o_out_item.out_byte, o_out_item.frame_type);
                fail_count++;
            end else begin
                want = frame_bytes_due.pop_front();
                check_field("out_byte", want.out_byte, o_out_item.out_byte);
                check_field("frame_type", want.frame_type, o_out_item.frame_type);
                check_field("first_of_frame", 8'(want.first_of_frame),
                            8'(o_out_item.first_of_frame));
                check_field("last_of_frame", 8'(want.last_of_frame),
                            8'(o_out_item.last_of_frame));
                check_field("aborted", 8'(want.aborted), 8'(o_out_item.aborted));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tlv_sync_frame_parser: mismatch");
            $finish;
        end
    end

    initial begin
        t_link_setup setup;
        int          slot, len, cap, sent, cut;
        logic [7:0]  s0, s1, tbyte;

        cfg.sync        = RST_SYNC_BYTES;
        cfg.types       = RST_TYPE_CODES;
        cfg.fixed       = RST_FIXED_LENGTHS;
        cfg.max_payload = RST_MAX_PAYLOAD;
        cfg.mic_max     = RST_MIC_MAX;
        cfg.audio       = 1'b0;
        held_type       = '0;
        restart_hunt();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // defaults: sync AA 55, types 01..04, fixed lengths 0, audio off
        script.push_back(row(1'b0, 8'h00, 0));
        script.push_back(row(1'b0, 8'hAA));
        script.push_back(row(1'b0, 8'hAA));     // repeated first sync
        script.push_back(row(1'b0, 8'h55));
        script.push_back(row(1'b0, 8'hAA));     // bad type that equals first sync
        script.push_back(row(1'b0, 8'h55));
        script.push_back(row(1'b0, 8'h01));
        script.push_back(row(1'b0, 8'h00));
        script.push_back(row(1'b0, 8'h00, 3,
                             frame_byte(8'h01, 8'h01, 1'b1, 1'b0, 1'b0),
                             frame_byte(8'h00, 8'h01, 1'b0, 1'b0, 1'b0),
                             frame_byte(8'h00, 8'h01, 1'b0, 1'b1, 1'b0)));
        script.push_back(row(1'b0, 8'hAA));
        script.push_back(row(1'b0, 8'h55));
        script.push_back(row(1'b0, 8'h04));
        script.push_back(row(1'b0, 8'h00));
        script.push_back(row(1'b0, 8'h02, 0));  // microphone with audio off
        script.push_back(row(1'b1, 8'hFF, 0));  // resync outside a payload
        run_script();
        settle();

        // equal sync bytes, keyboard and absolute mouse share code 01
        setup.sync        = 16'h7E7E;
        setup.types       = 32'h0401_FF01;
        setup.fixed       = 48'h0000_FFFF_0001;
        setup.max_payload = 16'hFFFF;
        setup.mic_max     = 16'h0000;
        setup.audio       = 1'b1;
        load_setup(setup);
        script.push_back(row(1'b0, 8'h7E));
        script.push_back(row(1'b0, 8'h7E));
        script.push_back(row(1'b0, 8'h04));
        script.push_back(row(1'b0, 8'h00));
        script.push_back(row(1'b0, 8'h02));
        script.push_back(row(1'b0, 8'hFF));
        script.push_back(row(1'b1, 8'h00, 1, frame_byte(8'h00, 8'h04, 1'b0, 1'b0, 1'b1)));
        script.push_back(row(1'b0, 8'h7E));
        script.push_back(row(1'b0, 8'h7E));
        script.push_back(row(1'b0, 8'h01));
        script.push_back(row(1'b0, 8'h00));
        script.push_back(row(1'b0, 8'h01));
        script.push_back(row(1'b0, 8'h5A, 1, frame_byte(8'h5A, 8'h01, 1'b0, 1'b1, 1'b0)));
        run_script();
        settle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            setup.sync = 16'($urandom);
            if ($urandom_range(0, 3) == 0) setup.sync[7:0] = setup.sync[15:8];
            setup.types = $urandom;
            if ($urandom_range(0, 2) == 0) setup.types[15:8] = setup.types[31:24];
            setup.fixed = {16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)),
                           16'($urandom_range(0, 6))};
            setup.max_payload = $urandom_range(0, 1) ? 16'd512 : 16'($urandom_range(2, 20));
            setup.mic_max     = 16'($urandom_range(0, 20));
            setup.audio       = 1'($urandom_range(0, 1));
            if (p == 0) begin
                setup.sync        = 16'h0000;
                setup.types       = 32'h0000_0000;
                setup.max_payload = 16'h0000;
                setup.mic_max     = 16'hFFFF;
                setup.audio       = 1'b1;
            end else if (p == 1) begin
                setup.sync         = 16'hFFFF;
                setup.fixed[31:16] = 16'hFFFF;
                setup.max_payload  = 16'hFFFF;
                setup.mic_max      = 16'h0000;
                setup.audio        = 1'b1;
            end else if (p == 2) begin
                setup.audio = 1'b0;
            end
            load_setup(setup);
            if (p == 2) hold_request = 1'b1;
            if (p == NUM_PHASES - 1) calm = 1'b1;
            s0   = cfg.sync[15:8];
            s1   = cfg.sync[7:0];
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                burst.delete();
                case ($urandom_range(0, 9))
                    7: repeat ($urandom_range(1, 5)) burst.push_back(data_item(8'($urandom)));
                    8: burst.push_back(resync_item());
                    9: begin
                        burst.push_back(data_item(s0));
                        burst.push_back(data_item(8'($urandom)));
                        burst.push_back(data_item(8'($urandom)));
                    end
                    default: begin
                        // mostly a frame that passes the checks, payload kept short
                        tbyte = cfg.types[8*$urandom_range(0, 3) +: 8];
                        slot  = slot_of(tbyte);
                        if (slot < 3) begin
                            len = int'(cfg.fixed[16*slot +: 16]);
                        end else begin
                            cap = (cfg.mic_max != 0 && cfg.mic_max < cfg.max_payload) ?
                                  int'(cfg.mic_max) : int'(cfg.max_payload);
                            if (cap > LEN_CAP) cap = LEN_CAP;
                            len = (cap >= 2) ? 2 * $urandom_range(1, cap / 2) : 2;
                        end
                        if (len > LEN_CAP || $urandom_range(0, 4) == 0)
                            len = $urandom_range(0, LEN_CAP);
                        if ($urandom_range(0, 7) == 0) tbyte = 8'($urandom);
                        burst.push_back(data_item(s0));
                        burst.push_back(data_item(s1));
                        burst.push_back(data_item(tbyte));
                        burst.push_back(data_item(8'(len >> 8)));
                        burst.push_back(data_item(8'(len)));
                        cut = ($urandom_range(0, 5) == 0) ? $urandom_range(0, len) : len;
                        for (int k = 0; k < len; k++) begin
                            if (k == cut) begin
                                burst.push_back(resync_item());
                                break;
                            end
                            burst.push_back(data_item(8'($urandom)));
                        end
                    end
                endcase
                foreach (burst[k]) send_byte(burst[k], 1'b1);
                sent += burst.size();
            end
            settle();
        end

        if (fail_count == 0 && frame_bytes_due.size() == 0)
            $display("tlv_sync_frame_parser: match");
        else
            $display("tlv_sync_frame_parser: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/tsfp_pkg.sv
src/tsfp_queue.sv
src/tsfp_front.sv
src/tsfp_back.sv
src/tlv_sync_frame_parser.sv
verif/tb_tlv_sync_frame_parser.sv
